// ----- design/bpgc_pkg.sv -----
`default_nettype none
package bpgc_pkg;

    // Field widths
    localparam int TIME_W   = 32;
    localparam int MS_CFG_W = 16;
    localparam int COUNT_W  = 8;
    localparam int COLOUR_W = 2;
    localparam int GROUP_W  = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NOISE_MS         = 3'd0,
        REG_SHORT_MAX_MS     = 3'd1,
        REG_LONG_MAX_MS      = 3'd2,
        REG_REPEAT_WINDOW_MS = 3'd3,
        REG_SETTLE_MS        = 3'd4,
        REG_CALIB_REPEATS    = 3'd5
    } cfg_reg_t;

    // Register reset values
    localparam logic [MS_CFG_W-1:0] NOISE_MS_RST         = 16'd25;
    localparam logic [MS_CFG_W-1:0] SHORT_MAX_MS_RST     = 16'd1000;
    localparam logic [MS_CFG_W-1:0] LONG_MAX_MS_RST      = 16'd5000;
    localparam logic [MS_CFG_W-1:0] REPEAT_WINDOW_MS_RST = 16'd400;
    localparam logic [MS_CFG_W-1:0] SETTLE_MS_RST        = 16'd500;
    localparam logic [COUNT_W-1:0]  CALIB_REPEATS_RST    = 8'd10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Hold colour codes
    localparam logic [COLOUR_W-1:0] COLOUR_NONE      = 2'd0;
    localparam logic [COLOUR_W-1:0] COLOUR_SHORT     = 2'd1;
    localparam logic [COLOUR_W-1:0] COLOUR_LONG      = 2'd2;
    localparam logic [COLOUR_W-1:0] COLOUR_VERY_LONG = 2'd3;

    // Group event codes
    localparam logic [GROUP_W-1:0] GROUP_NONE  = 2'd0;
    localparam logic [GROUP_W-1:0] GROUP_MODE  = 2'd1;
    localparam logic [GROUP_W-1:0] GROUP_CALIB = 2'd2;

endpackage
`default_nettype wire

// ----- design/bpgc_if.sv -----
`default_nettype none
interface bpgc_in_if;
    logic                          valid;
    logic                          ready;
    logic                          button_level;
    logic [bpgc_pkg::TIME_W-1:0]   now_ms;

    modport source (output valid, output button_level, output now_ms, input ready);
    modport sink   (input valid, input button_level, input now_ms, output ready);
endinterface

interface bpgc_out_if;
    logic                            valid;
    logic                            ready;
    logic [bpgc_pkg::COLOUR_W-1:0]   hold_colour;
    logic                            release_event;
    logic [bpgc_pkg::GROUP_W-1:0]    group_event;

    modport source (output valid, output hold_colour, output release_event,
                    output group_event, input ready);
    modport sink   (input valid, input hold_colour, input release_event,
                    input group_event, output ready);
endinterface
`default_nettype wire

// ----- design/button_press_gesture_classifier_core.sv -----
`default_nettype none
// Channel   Dir   Payload                                     Beat
// sample    in    button_level, now_ms                        valid && ready
// result    out   hold_colour, release_event, group_event     valid && ready
// cfg       in    cfg_index, cfg_wdata                        cfg_we
//
// The press state and the result register load at the edge that accepts the
// sample, so a new sample can enter every cycle unless the result stalls.
// Reset restores the register defaults and clears all press state.
// A stalled result holds in the result register; sample.ready drops only
// while that register is full and not being taken.
module button_press_gesture_classifier_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [bpgc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [bpgc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    bpgc_in_if.sink                            sample,
    bpgc_out_if.source                         result
);
    import bpgc_pkg::*;

    // Configuration registers
    logic [MS_CFG_W-1:0] noise_reg;
    logic [MS_CFG_W-1:0] short_max_reg;
    logic [MS_CFG_W-1:0] long_max_reg;
    logic [MS_CFG_W-1:0] window_reg;
    logic [MS_CFG_W-1:0] settle_reg;
    logic [COUNT_W-1:0]  calib_reg;

    // Press state
    logic               pressed_reg,  pressed_next;
    logic               pending_reg,  pending_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic [TIME_W-1:0]  last_reg,     last_next;
    logic [TIME_W-1:0]  start_reg,    start_next;

    // Result register
    logic                out_valid_reg;
    logic [COLOUR_W-1:0] colour_reg, colour_next;
    logic                rel_reg,    rel_next;
    logic [GROUP_W-1:0]  group_reg,  group_next;

    logic              in_beat;
    logic [TIME_W-1:0] held_d;
    logic [TIME_W-1:0] since_short;
    logic [TIME_W-1:0] since_last;
    logic [TIME_W-1:0] noise_ext, short_ext, long_ext, window_ext, settle_ext;

    assign sample.ready = !out_valid_reg || result.ready;
    assign in_beat      = sample.valid && sample.ready;

    assign noise_ext  = TIME_W'(noise_reg);
    assign short_ext  = TIME_W'(short_max_reg);
    assign long_ext   = TIME_W'(long_max_reg);
    assign window_ext = TIME_W'(window_reg);
    assign settle_ext = TIME_W'(settle_reg);

    // Take configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            noise_reg     <= NOISE_MS_RST;
            short_max_reg <= SHORT_MAX_MS_RST;
            long_max_reg  <= LONG_MAX_MS_RST;
            window_reg    <= REPEAT_WINDOW_MS_RST;
            settle_reg    <= SETTLE_MS_RST;
            calib_reg     <= CALIB_REPEATS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_NOISE_MS:         noise_reg     <= cfg_wdata;
                REG_SHORT_MAX_MS:     short_max_reg <= cfg_wdata;
                REG_LONG_MAX_MS:      long_max_reg  <= cfg_wdata;
                REG_REPEAT_WINDOW_MS: window_reg    <= cfg_wdata;
                REG_SETTLE_MS:        settle_reg    <= cfg_wdata;
                REG_CALIB_REPEATS:    calib_reg     <= cfg_wdata[COUNT_W-1:0];
                default:              ;
            endcase
        end
    end

    // Classify one sample
    always_comb
    begin
        pressed_next = pressed_reg;
        pending_next = pending_reg;
        count_next   = count_reg;
        last_next    = last_reg;
        start_next   = start_reg;
        colour_next  = COLOUR_NONE;
        rel_next     = 1'b0;
        group_next   = GROUP_NONE;

        // held time is zero on the first pressed sample
        held_d      = (sample.button_level && !pressed_reg) ? '0
                                                            : sample.now_ms - start_reg;
        since_short = sample.now_ms - last_reg;

        if (sample.button_level)
        begin
            if (!pressed_reg)
            begin
                pressed_next = 1'b1;
                start_next   = sample.now_ms;
            end
            // highest matching range wins
            if (held_d > long_ext)
                colour_next = COLOUR_VERY_LONG;
            else if (held_d > short_ext && held_d < long_ext)
                colour_next = COLOUR_LONG;
            else if (held_d > noise_ext && held_d < short_ext)
                colour_next = COLOUR_SHORT;
        end
        else if (pressed_reg)
        begin
            pressed_next = 1'b0;
            if (held_d > noise_ext)
            begin
                if (held_d < short_ext)
                begin
                    if (since_short < window_ext)
                    begin
                        if (count_reg != COUNT_MAX)
                            count_next = count_reg + COUNT_W'(1);
                    end
                    else
                        count_next = '0;
                    pending_next = 1'b1;
                    last_next    = sample.now_ms;
                end
                else if (held_d < long_ext)
                    rel_next = 1'b1;
            end
        end

        // resolve a settled group after the button handling
        since_last = sample.now_ms - last_next;
        if (pending_next && since_last > settle_ext)
        begin
            group_next   = (count_next >= calib_reg) ? GROUP_CALIB : GROUP_MODE;
            pending_next = 1'b0;
        end
    end

    // Advance press state on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pressed_reg <= 1'b0;
            pending_reg <= 1'b0;
            count_reg   <= '0;
            last_reg    <= '0;
            start_reg   <= '0;
        end
        else if (in_beat)
        begin
            pressed_reg <= pressed_next;
            pending_reg <= pending_next;
            count_reg   <= count_next;
            last_reg    <= last_next;
            start_reg   <= start_next;
        end
    end

    // Hold the result until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_beat)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            colour_reg <= colour_next;
            rel_reg    <= rel_next;
            group_reg  <= group_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.hold_colour   = colour_reg;
    assign result.release_event = rel_reg;
    assign result.group_event   = group_reg;

    // A resolved group leaves nothing pending
    a_group_clears_pending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && group_reg != GROUP_NONE |-> !pending_reg)
        else $error("group event shown while a press is still pending");

    // A release event comes from a sample with the button up
    a_release_not_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && rel_reg |-> colour_reg == COLOUR_NONE && !pressed_reg)
        else $error("release event with button still held");

    // A hold colour means the button is still down
    a_colour_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && colour_reg != COLOUR_NONE |-> pressed_reg)
        else $error("hold colour without a press in progress");

    // A pressed sample leaves the press flag set
    a_press_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat && sample.button_level |=> pressed_reg)
        else $error("press flag not set after a pressed sample");

    // No group code beyond calibration
    a_group_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> group_reg == GROUP_NONE || group_reg == GROUP_MODE
                          || group_reg == GROUP_CALIB)
        else $error("undefined group event code");

endmodule
`default_nettype wire
